// File: sv/sibs_pkg.sv
// Package for the sorted ID block list search block.
// Holds the field widths, the operation codes, parameter defaults and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sibs_pkg;

    localparam int unsigned ID_W            = 32;
    localparam int unsigned POS_W           = 11;
    localparam int unsigned OP_W            = 2;
    localparam int unsigned MAX_TABLES      = 2;
    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_TABLE_COUNT = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// File: sv/sorted_id_blocklist_search_top.sv
// Top level of the sorted ID block list search block: tables, counts and search controller.
// Depends on sibs_pkg for widths, operation codes and the state type.
// The ID tables live in one synchronous memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps up to two tables of ascending 32-bit IDs in a single on-chip memory of
// TABLE_COUNT * TABLE_DEPTH words, with a per-table entry count held in flip-flops. Every
// input transaction produces exactly one result transaction. A clear resets one table's
// count, and an append writes the ID at the end of a table. Both go straight to the
// response state, from which the result moves into the output register once it is free.
// An append to a full table is refused and reported through full_error. A search runs a
// binary search over table 0 and then, if table 0 gave no hit, over table 1, skipping
// empty tables. It uses truncating midpoints and stops at the first equal entry. Each
// probe issues the memory read in the probe state and compares the read data in the
// compare state. A table whose search ends without a hit, or that is skipped as empty,
// takes one more pass through the probe state to notice that its window is closed. A
// table of n entries needs at most floor(log2 n) + 1 probes. One transaction is
// processed at a time. A new one is accepted once the controller is back in idle, which
// it enters as the previous result moves into the output register, even while that
// result still waits there. The memory needs no clearing after reset, because a search
// only reads entries below the count, and appends have written all of those.
module sorted_id_blocklist_search_top
    import sibs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int unsigned TABLE_COUNT = DEF_TABLE_COUNT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic             table_sel,
    input  wire logic [ID_W-1:0]  value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  found,
    output logic [POS_W-1:0]      position,
    output logic                  hit_table,
    output logic                  full_error
);

    // Widths derived from the table geometry.
    localparam int unsigned MEM_DEPTH = TABLE_COUNT * TABLE_DEPTH;
    localparam int unsigned MW        = $clog2(MEM_DEPTH);
    localparam int unsigned AW        = $clog2(TABLE_DEPTH);
    localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);

    localparam logic [MW-1:0] TABLE1_BASE = MW'(TABLE_DEPTH);
    localparam logic [CW-1:0] FULL_COUNT  = CW'(TABLE_DEPTH);
    localparam logic          LAST_TABLE  = 1'(TABLE_COUNT - 1);

    // ID memory, written by appends and read by search probes.
    logic [ID_W-1:0] mem [MEM_DEPTH];
    logic            mem_we;
    logic [MW-1:0]   mem_waddr;
    logic [MW-1:0]   mem_raddr;
    logic [ID_W-1:0] rd_data_reg;

    // Controller state.
    state_t state_reg, state_next;

    // Entry counts; the second one stays zero when only one table exists.
    logic [CW-1:0] count_reg [MAX_TABLES];
    logic [CW-1:0] count_next [MAX_TABLES];

    // Search working registers. The window is [first, bound), so bound is last + 1.
    logic            tbl_reg, tbl_next;
    logic [CW-1:0]   first_reg, first_next;
    logic [CW-1:0]   bound_reg, bound_next;
    logic [AW-1:0]   mid_reg, mid_next;
    logic [ID_W-1:0] target_reg, target_next;

    // Result waiting to move into the output register.
    logic             res_found_reg, res_found_next;
    logic [POS_W-1:0] res_pos_reg, res_pos_next;
    logic             res_hit_reg, res_hit_next;
    logic             res_full_reg, res_full_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic             hit_table_reg, hit_table_next;
    logic             full_error_reg, full_error_next;

    logic          in_fire;
    logic          out_free;
    logic          table_ok;
    logic          window_open;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;
    logic          probe_eq;
    logic          probe_lt;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign table_ok  = (TABLE_COUNT > 1) || !table_sel;

    // Truncating midpoint of [first, bound - 1]; the window is known to be nonempty here.
    assign window_open = (first_reg < bound_reg);
    assign mid_sum     = {1'b0, first_reg} + {1'b0, bound_reg} - (CW + 1)'(1);
    assign mid_calc    = AW'(mid_sum >> 1);

    assign probe_eq = (rd_data_reg == target_reg);
    assign probe_lt = (rd_data_reg < target_reg);

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign hit_table  = hit_table_reg;
    assign full_error = full_error_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (op == OP_SEARCH) ? S_PROBE : S_RESP;
                end
            end
            S_PROBE:
            begin
                if (window_open)
                begin
                    state_next = S_CMP;
                end
                else if (tbl_reg == LAST_TABLE)
                begin
                    state_next = S_RESP;
                end
            end
            S_CMP:
            begin
                state_next = probe_eq ? S_RESP : S_PROBE;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and outputs.
    always_comb
    begin
        count_next      = count_reg;
        tbl_next        = tbl_reg;
        first_next      = first_reg;
        bound_next      = bound_reg;
        mid_next        = mid_reg;
        target_next     = target_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        res_hit_next    = res_hit_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        position_next   = position_reg;
        hit_table_next  = hit_table_reg;
        full_error_next = full_error_reg;
        mem_we          = 1'b0;
        mem_waddr       = MW'(count_reg[table_sel][AW-1:0]) + (table_sel ? TABLE1_BASE : '0);
        mem_raddr       = MW'(mid_calc) + (tbl_reg ? TABLE1_BASE : '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_hit_next   = 1'b0;
                    res_full_next  = 1'b0;
                    target_next    = value;
                    tbl_next       = 1'b0;
                    first_next     = '0;
                    bound_next     = count_reg[0];
                    case (op)
                        OP_CLEAR:
                        begin
                            if (table_ok)
                            begin
                                count_next[table_sel] = '0;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (table_ok)
                            begin
                                if (count_reg[table_sel] >= FULL_COUNT)
                                begin
                                    res_full_next = 1'b1;
                                end
                                else
                                begin
                                    mem_we                = 1'b1;
                                    count_next[table_sel] = count_reg[table_sel] + CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // Search starts in the probe state; the unused code does nothing.
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (window_open)
                begin
                    mid_next = mid_calc;
                end
                else if (tbl_reg != LAST_TABLE)
                begin
                    tbl_next   = 1'b1;
                    first_next = '0;
                    bound_next = count_reg[1];
                end
            end
            S_CMP:
            begin
                if (probe_eq)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_W'({1'b0, mid_reg} + (AW + 1)'(1));
                    res_hit_next   = tbl_reg;
                end
                else if (probe_lt)
                begin
                    first_next = CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    bound_next = CW'(mid_reg);
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = res_found_reg;
                    position_next   = res_pos_reg;
                    hit_table_next  = res_hit_reg;
                    full_error_next = res_full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TABLES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg        <= tbl_next;
        first_reg      <= first_next;
        bound_reg      <= bound_next;
        mid_reg        <= mid_next;
        target_reg     <= target_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        res_hit_reg    <= res_hit_next;
        res_full_reg   <= res_full_next;
        found_reg      <= found_next;
        position_reg   <= position_next;
        hit_table_reg  <= hit_table_next;
        full_error_reg <= full_error_next;
    end

    // The memory has one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= value;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the sorted ID block list search block.
// Depends on sibs_pkg and sorted_id_blocklist_search_top; a small scoreboard class predicts
// every result from its own copy of both ID tables and their entry counts.
`timescale 1ns / 1ps

module tb_top
    import sibs_pkg::*;
();

    // The block runs with its default geometry, so the tables below mirror that size.
    localparam int unsigned TBL_DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned TBL_COUNT = DEF_TABLE_COUNT;

    // Op code 3 has no meaning in the block; it must be ignored with an all-zero result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 860;
    localparam int LONG_HOLD      = 400;   // cycles the result side refuses transactions
    localparam int HOLD_AT_ITEM   = 300;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any accepted transaction
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 64;    // longer than the slowest search
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             hit_table;
        logic             full_error;
    } lookup_result_t;

    // Gap pattern shared by both sides; each side still draws its own gaps.
    typedef enum logic [1:0] {
        PACE_NONE,
        PACE_FULL,
        PACE_SPARSE
    } pace_t;

    // Scoreboard: keeps both tables, predicts the result of each accepted
    // transaction and checks results in order.
    class blocklist_checker;
        logic [ID_W-1:0] ids [TBL_COUNT][TBL_DEPTH];
        int unsigned     fill [TBL_COUNT];
        lookup_result_t  awaited[$];
        int              mismatches;
        int              checked;
        int              n_clear;
        int              n_append;
        int              n_refused;
        int              n_search;
        int              n_hit;
        int              n_hit_t1;
        int              n_ignored;

        function new();
            for (int t = 0; t < TBL_COUNT; t++)
                fill[t] = 0;
            mismatches = 0;
            checked    = 0;
            n_clear    = 0;
            n_append   = 0;
            n_refused  = 0;
            n_search   = 0;
            n_hit      = 0;
            n_hit_t1   = 0;
            n_ignored  = 0;
        endfunction

        // Binary search with truncating midpoints; returns the 1-based position or 0.
        function int unsigned bisect_table(int t, logic [ID_W-1:0] target);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = int'(fill[t]) - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (ids[t][mid] < target)
                    lo = mid + 1;
                else if (ids[t][mid] == target)
                    return mid + 1;
                else
                    hi = mid - 1;
            end
            return 0;
        endfunction

        function lookup_result_t lookup_outcome(logic [OP_W-1:0] code, logic sel,
                                                logic [ID_W-1:0] val);
            lookup_result_t r;
            int unsigned    where;
            bit             done;
            r    = '0;
            done = 1'b0;
            case (code)
                OP_CLEAR:
                begin
                    n_clear++;
                    if (sel < TBL_COUNT)
                        fill[sel] = 0;
                end
                OP_APPEND:
                begin
                    n_append++;
                    if (sel < TBL_COUNT)
                    begin
                        if (fill[sel] >= TBL_DEPTH)
                        begin
                            r.full_error = 1'b1;
                            n_refused++;
                        end
                        else
                        begin
                            ids[sel][fill[sel]] = val;
                            fill[sel]++;
                        end
                    end
                end
                OP_SEARCH:
                begin
                    n_search++;
                    for (int t = 0; t < TBL_COUNT; t++)
                    begin
                        if (!done && fill[t] != 0)
                        begin
                            where = bisect_table(t, val);
                            if (where != 0)
                            begin
                                r.found     = 1'b1;
                                r.position  = where[POS_W-1:0];
                                r.hit_table = t[0];
                                done        = 1'b1;
                                n_hit++;
                                if (t == 1)
                                    n_hit_t1++;
                            end
                        end
                    end
                end
                default:
                    n_ignored++;
            endcase
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] code, logic sel, logic [ID_W-1:0] val);
            awaited.push_back(lookup_outcome(code, sel, val));
        endfunction

        function void check_response(logic fnd, logic [POS_W-1:0] pos, logic hit, logic full);
            lookup_result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing awaited: found=%0d pos=%0d table=%0d",
                             $time, fnd, pos, hit);
                return;
            end
            want = awaited.pop_front();
            if (want.found !== fnd || want.position !== pos || want.hit_table !== hit
                || want.full_error !== full)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch: expected found=%0d pos=%0d table=%0d full=%0d",
                             $time, want.found, want.position, want.hit_table,
                             want.full_error);
                    $display("    got found=%0d pos=%0d table=%0d full=%0d",
                             fnd, pos, hit, full);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [OP_W-1:0]  op;
    logic             table_sel;
    logic [ID_W-1:0]  value;
    logic             out_valid;
    logic             out_ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             hit_table;
    logic             full_error;

    blocklist_checker sb;
    pace_t            pace;
    bit               hold_outputs;
    int               requests_sent;

    sorted_id_blocklist_search_top #(
        .TABLE_DEPTH (TBL_DEPTH),
        .TABLE_COUNT (TBL_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .table_sel  (table_sel),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .hit_table  (hit_table),
        .full_error (full_error)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Wait before one transaction, following the current pace. Sparse pace leaves long
    // runs of back-to-back transactions with an occasional gap.
    function automatic int draw_gap();
        case (pace)
            PACE_NONE:   return 0;
            PACE_FULL:   return $urandom_range(0, 17);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    // Drives one request transaction. It is entered at a falling edge and returns at the
    // falling edge after acceptance, so the scoreboard already holds the updated tables
    // when the caller chooses the next item. Valid is only lowered when a gap follows,
    // which keeps it high across back-to-back transactions.
    task automatic send_request(input logic [OP_W-1:0] code, input logic sel,
                                input logic [ID_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op        <= code;
        table_sel <= sel;
        value     <= val;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
        requests_sent++;
    endtask

    // Picks a search target: mostly an ID that is stored in one of the tables, sometimes
    // a neighbor of one, an extreme, or a fully random value.
    function automatic logic [ID_W-1:0] pick_target();
        int          t;
        int unsigned kind;
        logic [ID_W-1:0] stored;
        kind = $urandom_range(0, 9);
        t    = $urandom_range(0, TBL_COUNT - 1);
        if (sb.fill[t] == 0)
            t = TBL_COUNT - 1 - t;
        if (sb.fill[t] == 0 || kind >= 8)
            return $urandom;
        stored = sb.ids[t][$urandom_range(0, sb.fill[t] - 1)];
        case (kind)
            5:       return stored + 1;
            6:       return stored - 1;
            7:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return stored;
        endcase
    endfunction

    // Appends count ascending IDs to one table. Narrow batches crowd the IDs together so
    // that duplicates and close neighbors show up.
    task automatic append_sorted(input logic sel, input int count, input bit narrow);
        logic [ID_W-1:0] batch[$];
        logic [ID_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < count; i++)
        begin
            if (narrow)
                batch.push_back(base + $urandom_range(0, 4 * count + 3));
            else
                batch.push_back($urandom);
        end
        batch.sort();
        foreach (batch[i])
            send_request(OP_APPEND, sel, batch[i]);
    endtask

    // Both monitors sample on the rising edge, before the block's registers update.
    // Results are checked before the new request is noted, though either order works.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_response(found, position, hit_table, full_error);
            if (in_valid && in_ready)
                sb.note_request(op, table_sel, value);
        end
    end

    // Result side: a random wait before each transaction, and once a long hold-off
    // during which the request side keeps offering, so the block fills up and stalls.
    initial
    begin : result_sink
        int wait_cycles;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_outputs)
            begin
                wait_cycles  = LONG_HOLD;
                hold_outputs = 1'b0;
            end
            else
            begin
                wait_cycles = draw_gap();
            end
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Ends the run when no transaction on either side has been accepted for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No transaction accepted for %0d cycles.", WATCHDOG_LIMIT);
        $display("[sorted_id_blocklist_search_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int  random_items;
        int  count;
        int  searches;
        int  waited;
        bit  held;
        logic sel;
        logic [OP_W-1:0] code;

        sb            = new();
        pace          = PACE_FULL;
        hold_outputs  = 1'b0;
        requests_sent = 0;
        random_items  = 0;
        held          = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_CLEAR;
        table_sel     = 1'b0;
        value         = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Searching with both tables empty, then the unknown op.
        send_request(OP_SEARCH, 1'b0, '0);
        send_request(OP_UNUSED, 1'b1, '1);
        // Table 0 holds the extremes, table 1 shares the ID 100 with table 0.
        send_request(OP_APPEND, 1'b0, 32'd0);
        send_request(OP_APPEND, 1'b0, 32'd5);
        send_request(OP_APPEND, 1'b0, 32'd100);
        send_request(OP_APPEND, 1'b0, '1);
        send_request(OP_APPEND, 1'b1, 32'd7);
        send_request(OP_APPEND, 1'b1, 32'd100);
        send_request(OP_SEARCH, 1'b1, 32'd0);
        send_request(OP_SEARCH, 1'b0, '1);
        send_request(OP_SEARCH, 1'b1, 32'd100);   // both tables hold it; table 0 wins
        send_request(OP_SEARCH, 1'b0, 32'd7);     // miss in table 0, hit in table 1
        send_request(OP_SEARCH, 1'b0, 32'd6);
        // With table 0 empty it is skipped and the match comes from table 1.
        send_request(OP_CLEAR, 1'b0, 32'hDEAD_BEEF);
        send_request(OP_SEARCH, 1'b0, 32'd100);
        // An unsorted table: the probe path finds 10 and 30 but misses 50.
        send_request(OP_APPEND, 1'b0, 32'd50);
        send_request(OP_APPEND, 1'b0, 32'd10);
        send_request(OP_APPEND, 1'b0, 32'd30);
        send_request(OP_SEARCH, 1'b0, 32'd10);
        send_request(OP_SEARCH, 1'b0, 32'd30);
        send_request(OP_SEARCH, 1'b0, 32'd50);
        send_request(OP_CLEAR, 1'b1, '1);
        send_request(OP_SEARCH, 1'b1, 32'd7);

        // Random part: mostly well-formed episodes (clear, ascending appends, searches),
        // the rest noise that includes unsorted appends and the unknown op.
        while (random_items < RANDOM_ITEMS)
        begin
            pace = pace_t'($urandom_range(0, 2));
            if (!held && random_items >= HOLD_AT_ITEM)
            begin
                held         = 1'b1;
                hold_outputs = 1'b1;
                pace         = PACE_NONE;
            end
            sel = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 80)
            begin
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                    : $urandom_range(0, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    send_request(OP_CLEAR, sel, $urandom);
                    random_items++;
                end
                append_sorted(sel, count, 1'($urandom_range(0, 1)));
                random_items += count;
                searches = $urandom_range(1, 12);
                for (int i = 0; i < searches; i++)
                    send_request(OP_SEARCH, 1'($urandom_range(0, 1)), pick_target());
                random_items += searches;
            end
            else
            begin
                count = $urandom_range(1, 6);
                for (int i = 0; i < count; i++)
                begin
                    code = OP_W'($urandom_range(0, 3));
                    send_request(code, 1'($urandom_range(0, 1)), $urandom);
                    if (code != OP_UNUSED)
                        random_items++;
                end
            end
        end
        in_valid <= 1'b0;

        // Wait for every expected result, then a little longer for stray ones.
        waited = 0;
        while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (sb.awaited.size() != 0)
        begin
            $display("%0d results still outstanding at the end.", sb.awaited.size());
            $display("[sorted_id_blocklist_search_top] ERROR");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            $display("Sent %0d transactions: %0d clears, %0d appends (%0d refused as full),",
                     requests_sent, sb.n_clear, sb.n_append, sb.n_refused);
            $display("%0d searches, %0d hits (%0d in table 1), %0d unknown ops, %0d mismatches.",
                     sb.n_search, sb.n_hit, sb.n_hit_t1, sb.n_ignored, sb.mismatches);
            if (sb.mismatches == 0 && sb.awaited.size() == 0)
                $display("[sorted_id_blocklist_search_top] OK");
            else
                $display("[sorted_id_blocklist_search_top] ERROR");
            $finish;
        end
    end

endmodule

// File: sim.f
sv/sibs_pkg.sv
sv/sorted_id_blocklist_search_top.sv
bench/tb_top.sv
